>>> design/ovpc_pkg.sv
`default_nettype none

package ovpc_pkg;

    typedef enum logic [2:0] {
        FUNC_CTRL_WRITE = 3'd0,
        FUNC_AUTOMAP    = 3'd1,
        FUNC_SOFT_RESET = 3'd2,
        FUNC_HARD_RESET = 3'd3,
        FUNC_ACCESS     = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        TGT_MACHINE = 2'd0,
        TGT_EPROM   = 2'd1,
        TGT_RAM     = 2'd2
    } target_t;

    localparam logic CFG_IDX_ENABLED = 1'b0;
    localparam logic CFG_IDX_WP      = 1'b1;

    localparam int CTRL_CONMEM_BIT = 7;
    localparam int CTRL_MAPRAM_BIT = 6;
    localparam logic [7:0] CTRL_MAPRAM_MASK = 8'h40;
    localparam int MAPRAM_BANK = 3;

    typedef struct packed {
        logic [7:0]  control_value;
        logic        write_allowed;
        logic [12:0] page_offset;
        logic [1:0]  ram_bank;
        logic [1:0]  target;
        logic        paged_in;
    } result_t;

endpackage

`default_nettype wire

>>> design/overlay_paging_controller.sv
`default_nettype none

// Overlay paging controller for a 16K low-memory interface.
// Requests enter on s_axis: tuser carries the function code (control write,
// automap update, soft reset, hard reset, memory access), tdata the operands.
// Each request gives exactly one result on m_axis: paged-in flag, decoded
// target (machine memory, EPROM, RAM bank), page offset, write permission
// and the control byte after the request.
// The state update and the decode are done in the cycle the request is
// taken, and the result lands in the output register.
// Throughput is one request per clock while m_axis_tready is high.
// When the receiver stalls, the output register holds its result and
// s_axis_tready drops until that result is taken; if the result leaves in
// the same cycle, a new request is taken at once.
// Configuration (interface enable, EPROM write protect) is written through
// cfg_we/cfg_addr/cfg_wdata, with no read-back.
// Reset clears control byte, automap and paged-in flags, enables the
// interface, clears write protect and empties the output register.
module overlay_paging_controller
    import ovpc_pkg::*;
#(
    parameter int RAM_BANKS = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic        cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] write_data, [8] automap_level, [24:9] cpu_address, [25] is_write
    input  wire logic [31:0] s_axis_tdata,
    // [2:0] func
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] paged_in, [2:1] target, [4:3] ram_bank, [17:5] page_offset,
    // [18] write_allowed, [26:19] control_value
    output logic [31:0]      m_axis_tdata
);

    localparam int BANK_W = (RAM_BANKS > 4) ? $clog2(RAM_BANKS) : 2;
    localparam logic [BANK_W-1:0] BANK_MASK = BANK_W'(RAM_BANKS - 1);
    localparam logic [BANK_W-1:0] MAPRAM_BANK_W = BANK_W'(MAPRAM_BANK);

    logic        enabled_reg;
    logic        wp_reg;
    logic [7:0]  control_reg;
    logic [7:0]  control_next;
    logic        automap_reg;
    logic        automap_next;
    logic        active_reg;
    logic        active_next;
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     result_next;

    logic        accept;
    func_t       func;
    logic [7:0]  write_data;
    logic        automap_level;
    logic [15:0] cpu_address;
    logic [BANK_W-1:0] upper_bank;
    logic        lower;

    function automatic logic paging(input logic [7:0] ctrl, input logic am, input logic wp);
        logic r;
        if (ctrl[CTRL_CONMEM_BIT])
            r = 1'b1;
        else if (wp || ctrl[CTRL_MAPRAM_BIT])
            r = am;
        else
            r = 1'b0;
        return r;
    endfunction

    assign func          = func_t'(s_axis_tuser);
    assign write_data    = s_axis_tdata[7:0];
    assign automap_level = s_axis_tdata[8];
    assign cpu_address   = s_axis_tdata[24:9];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign upper_bank = control_reg[BANK_W-1:0] & BANK_MASK;
    assign lower      = !cpu_address[13];

    always_comb
    begin
        control_next = control_reg;
        automap_next = automap_reg;
        active_next  = active_reg;
        result_next  = '0;
        case (func)
            FUNC_CTRL_WRITE:
            begin
                control_next = write_data | (control_reg & CTRL_MAPRAM_MASK);
                active_next  = paging(control_next, automap_reg, wp_reg);
            end
            FUNC_AUTOMAP:
            begin
                automap_next = automap_level;
                active_next  = paging(control_reg, automap_level, wp_reg);
            end
            FUNC_SOFT_RESET, FUNC_HARD_RESET:
            begin
                active_next = 1'b0;
                if (enabled_reg)
                begin
                    control_next = (func == FUNC_HARD_RESET) ? 8'h00
                                   : (control_reg & CTRL_MAPRAM_MASK);
                    automap_next = 1'b0;
                    active_next  = paging(control_next, 1'b0, wp_reg);
                end
            end
            FUNC_ACCESS:
            begin
                result_next.page_offset = cpu_address[12:0];
                if (active_reg && cpu_address[15:14] == 2'b00)
                begin
                    if (control_reg[CTRL_CONMEM_BIT])
                    begin
                        if (lower)
                        begin
                            result_next.target        = TGT_EPROM;
                            result_next.write_allowed = !wp_reg;
                        end
                        else
                        begin
                            result_next.target        = TGT_RAM;
                            result_next.ram_bank      = upper_bank[1:0];
                            result_next.write_allowed = 1'b1;
                        end
                    end
                    else if (control_reg[CTRL_MAPRAM_BIT])
                    begin
                        result_next.target = TGT_RAM;
                        if (lower)
                        begin
                            result_next.ram_bank      = 2'(MAPRAM_BANK);
                            result_next.write_allowed = 1'b0;
                        end
                        else
                        begin
                            result_next.ram_bank      = upper_bank[1:0];
                            result_next.write_allowed = (upper_bank != MAPRAM_BANK_W);
                        end
                    end
                    else
                    begin
                        if (lower)
                        begin
                            result_next.target = TGT_EPROM;
                        end
                        else
                        begin
                            result_next.target        = TGT_RAM;
                            result_next.ram_bank      = upper_bank[1:0];
                            result_next.write_allowed = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        result_next.paged_in      = active_next;
        result_next.control_value = control_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg <= 1'b1;
            wp_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_IDX_ENABLED: enabled_reg <= cfg_wdata;
                CFG_IDX_WP:      wp_reg      <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg   <= 8'h00;
            automap_reg   <= 1'b0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                control_reg   <= control_next;
                automap_reg   <= automap_next;
                active_reg    <= active_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, result_reg};

endmodule

`default_nettype wire

>>> dv/tb_overlay_paging_controller.sv
`default_nettype none

module tb_overlay_paging_controller;
    import ovpc_pkg::*;

    localparam int BANKS = 4;
    localparam int PAGE_8K = 'h2000;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_ITEMS = 130;
    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  data;
        logic        level;
        logic [15:0] addr;
        logic        is_write;
    } request_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [31:0] m_axis_tdata;

    // paging state as the block should hold it
    logic [7:0]  pg_ctrl = '0;
    logic        pg_automap = 1'b0;
    logic        pg_active = 1'b0;
    logic        pg_enabled = 1'b1;
    logic        pg_wp = 1'b0;

    request_t    req_queue[$];
    result_t     pending_results[$];
    request_t    offered;
    logic        calm = 1'b0;
    int          hold_left = 0;
    int          errors = 0;

    overlay_paging_controller #(.RAM_BANKS(BANKS)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic void repage();
        if (pg_ctrl[CTRL_CONMEM_BIT])
            pg_active = 1'b1;
        else if (pg_wp || pg_ctrl[CTRL_MAPRAM_BIT])
            pg_active = pg_automap;
        else
            pg_active = 1'b0;
    endfunction

    function automatic result_t apply_request(request_t r);
        result_t    res;
        logic [1:0] bank;
        logic       lower;
        res = '0;
        bank = 2'(pg_ctrl & 8'(BANKS - 1));
        lower = (r.addr < 16'(PAGE_8K));
        case (r.func)
            FUNC_CTRL_WRITE:
            begin
                pg_ctrl = r.data | (pg_ctrl & CTRL_MAPRAM_MASK);
                repage();
            end
            FUNC_AUTOMAP:
            begin
                pg_automap = r.level;
                repage();
            end
            FUNC_SOFT_RESET, FUNC_HARD_RESET:
            begin
                pg_active = 1'b0;
                if (pg_enabled)
                begin
                    if (r.func == FUNC_HARD_RESET)
                        pg_ctrl = '0;
                    else
                        pg_ctrl = pg_ctrl & CTRL_MAPRAM_MASK;
                    pg_automap = 1'b0;
                    repage();
                end
            end
            FUNC_ACCESS:
            begin
                res.page_offset = r.addr[12:0];
                if (pg_active && r.addr < 16'(2 * PAGE_8K))
                begin
                    if (!lower && (pg_ctrl[CTRL_CONMEM_BIT] || !pg_ctrl[CTRL_MAPRAM_BIT]))
                    begin
                        res.target = TGT_RAM;
                        res.ram_bank = bank;
                        res.write_allowed = 1'b1;
                    end
                    else if (pg_ctrl[CTRL_CONMEM_BIT])
                    begin
                        res.target = TGT_EPROM;
                        res.write_allowed = !pg_wp;
                    end
                    else if (pg_ctrl[CTRL_MAPRAM_BIT])
                    begin
                        res.target = TGT_RAM;
                        if (lower)
                            res.ram_bank = 2'(MAPRAM_BANK);
                        else
                        begin
                            res.ram_bank = bank;
                            res.write_allowed = (bank != 2'(MAPRAM_BANK));
                        end
                    end
                    else
                        res.target = TGT_EPROM;
                end
            end
            default: ;
        endcase
        res.paged_in = pg_active;
        res.control_value = pg_ctrl;
        return res;
    endfunction

    function automatic request_t random_request();
        request_t r;
        int       pick;
        r.data = 8'($urandom);
        r.level = 1'($urandom);
        r.addr = 16'($urandom);
        r.is_write = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45)
            r.func = FUNC_ACCESS;
        else if (pick < 65)
            r.func = FUNC_CTRL_WRITE;
        else if (pick < 80)
            r.func = FUNC_AUTOMAP;
        else if (pick < 87)
            r.func = FUNC_SOFT_RESET;
        else if (pick < 94)
            r.func = FUNC_HARD_RESET;
        else
            r.func = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
        // keep most accesses inside the overlaid 16K
        if (r.func == FUNC_ACCESS && $urandom_range(0, 3) != 0)
            r.addr[15:14] = 2'b00;
        return r;
    endfunction

    task automatic add_req(logic [2:0] f, logic [7:0] d, logic lv, logic [15:0] a, logic w);
        request_t r;
        r.func = f;
        r.data = d;
        r.level = lv;
        r.addr = a;
        r.is_write = w;
        req_queue.push_back(r);
    endtask

    task automatic write_cfg(logic idx, logic val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_IDX_ENABLED)
            pg_enabled = val;
        else
            pg_wp = val;
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (req_queue.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                pending_results.push_back(apply_request(offered));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (req_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 18))
                begin
                    offered = req_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {6'b0, offered.is_write, offered.addr,
                                     offered.level, offered.data};
                    s_axis_tuser <= offered.func;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : result_mon
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata[26:0]);
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %h", m_axis_tdata);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $write("mismatch: paged_in %0d/%0d target %0d/%0d bank %0d/%0d",
                                   want.paged_in, got.paged_in, want.target, got.target,
                                   want.ram_bank, got.ram_bank);
                            $display(" offset %h/%h wr %0d/%0d ctrl %h/%h (exp/act)",
                                     want.page_offset, got.page_offset,
                                     want.write_allowed, got.write_allowed,
                                     want.control_value, got.control_value);
                        end
                    end
                end
            end
            if (hold_left != 0)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= calm || ($urandom_range(0, 99) >= 18);
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    initial
    begin : sequencer
        logic phase_en[6];
        logic phase_wp[6];
        phase_en = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        phase_wp = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        write_cfg(CFG_IDX_ENABLED, 1'b1);
        write_cfg(CFG_IDX_WP, 1'b0);

        add_req(FUNC_ACCESS, 8'h00, 1'b0, 16'h0000, 1'b0);
        add_req(FUNC_CTRL_WRITE, 8'h80, 1'b0, 16'h0000, 1'b0);
        add_req(FUNC_ACCESS, 8'h00, 1'b0, 16'h0000, 1'b1);
        add_req(FUNC_ACCESS, 8'h00, 1'b0, 16'h3FFF, 1'b0);
        add_req(FUNC_ACCESS, 8'hFF, 1'b1, 16'hFFFF, 1'b1);
        add_req(FUNC_CTRL_WRITE, 8'h43, 1'b0, 16'h0000, 1'b0);
        add_req(FUNC_AUTOMAP, 8'h00, 1'b1, 16'h0000, 1'b0);
        add_req(FUNC_ACCESS, 8'h00, 1'b0, 16'h1FFF, 1'b0);
        add_req(FUNC_ACCESS, 8'h00, 1'b0, 16'h2000, 1'b1);
        add_req(FUNC_CTRL_WRITE, 8'h00, 1'b0, 16'h0000, 1'b0);
        add_req(FUNC_ACCESS, 8'h00, 1'b0, 16'h2001, 1'b1);
        add_req(FUNC_SPARE_FIRST, 8'hFF, 1'b1, 16'h0000, 1'b0);
        add_req(FUNC_SPARE_LAST, 8'h80, 1'b0, 16'h2000, 1'b1);
        add_req(FUNC_SOFT_RESET, 8'h00, 1'b0, 16'h0000, 1'b0);
        add_req(FUNC_HARD_RESET, 8'h00, 1'b0, 16'h0000, 1'b0);
        drain();

        // automap through write protect, then resets with the interface off
        write_cfg(CFG_IDX_WP, 1'b1);
        add_req(FUNC_AUTOMAP, 8'h00, 1'b1, 16'h0000, 1'b0);
        add_req(FUNC_ACCESS, 8'h00, 1'b0, 16'h0000, 1'b1);
        add_req(FUNC_CTRL_WRITE, 8'h80, 1'b0, 16'h0000, 1'b0);
        add_req(FUNC_ACCESS, 8'h00, 1'b0, 16'h0001, 1'b1);
        drain();
        write_cfg(CFG_IDX_ENABLED, 1'b0);
        add_req(FUNC_CTRL_WRITE, 8'hC3, 1'b0, 16'h0000, 1'b0);
        add_req(FUNC_AUTOMAP, 8'h00, 1'b1, 16'h0000, 1'b0);
        add_req(FUNC_SOFT_RESET, 8'h00, 1'b0, 16'h0000, 1'b0);
        add_req(FUNC_ACCESS, 8'h00, 1'b0, 16'h2000, 1'b0);
        add_req(FUNC_HARD_RESET, 8'h00, 1'b0, 16'h0000, 1'b0);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            calm = (ph == 2);
            write_cfg(CFG_IDX_ENABLED, phase_en[ph]);
            write_cfg(CFG_IDX_WP, phase_wp[ph]);
            if (ph == 3)
            begin
                @(posedge clk);
                hold_left <= HOLD_CYCLES;
            end
            repeat (PHASE_ITEMS) req_queue.push_back(random_request());
            drain();
        end

        if (errors == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
design/ovpc_pkg.sv
design/overlay_paging_controller.sv
dv/tb_overlay_paging_controller.sv
